// ===== src/sqba_pkg.sv =====
// Shared constants for the snoop query bus arbiter: command and action codes
// and the fixed field widths of the bus event and result beats.
// No dependencies.
package sqba_pkg;

    localparam int unsigned ID_W         = 4;
    localparam int unsigned CMD_W        = 3;
    localparam int unsigned ACT_W        = 2;
    localparam int unsigned ADDR_FIELD_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STORE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ANSWER    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CACHE_ACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEM_ACK   = 3'd4;

    localparam logic [ACT_W-1:0] ACT_QUERY      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MEMORY     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ_CACHE = 2'd2;

endpackage

// ===== src/snoop_query_bus_arbiter_top.sv =====
// Snoop query bus arbiter: takes one bus event per beat and issues at most one
// bus action per event. Throughput is one event per clock cycle while the
// result side accepts; every event is decided by the phase and id registers
// in the cycle it is accepted; its action goes to a one-deep result register.
// The input side stays ready while that register is empty or being drained the
// same cycle, so the only stall comes from backpressure on the result side.
// Load requests query the other caches round robin, starting after the
// requester; a single hit reads from that cache, no hit or a second hit goes
// to memory, and each wait phase ends on its acknowledge.
//
// Top level of the arbiter. Depends on sqba_pkg.
module snoop_query_bus_arbiter_top
    import sqba_pkg::*;
#(
    parameter int unsigned NUM_CACHES = 4,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [ID_W-1:0]         i_cache_id,
    input  logic [ADDR_FIELD_W-1:0] i_address,
    input  logic                    i_hit,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ACT_W-1:0]        o_action,
    output logic [ID_W-1:0]         o_target_cache,
    output logic [ADDR_FIELD_W-1:0] o_request_address,
    output logic [ID_W-1:0]         o_initiator,
    output logic                    o_is_store
);

    localparam int unsigned HELD_W = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
    localparam logic [ID_W:0] NumCachesW = (ID_W + 1)'(NUM_CACHES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUERY,
        PH_WAIT_CACHE,
        PH_WAIT_MEM
    } t_phase;

    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] id);
        logic [ID_W:0] s;
        s = {1'b0, id} + (ID_W + 1)'(1);
        return (s == NumCachesW) ? '0 : s[ID_W-1:0];
    endfunction

    t_phase              r_phase,     n_phase;
    logic [ID_W-1:0]     r_initiator, n_initiator;
    logic [ID_W-1:0]     r_queried,   n_queried;
    logic [ID_W-1:0]     r_supplier,  n_supplier;
    logic                r_hit_seen,  n_hit_seen;
    logic [HELD_W-1:0]   r_held_addr, n_held_addr;
    logic                r_is_store,  n_is_store;

    logic                r_out_valid;
    logic [ACT_W-1:0]    r_action,    n_action;
    logic [ID_W-1:0]     r_target,    n_target;
    logic [HELD_W-1:0]   r_out_addr;
    logic [ID_W-1:0]     r_out_init;
    logic                r_out_store;

    logic                in_accept;
    logic                emit;
    logic                id_ok;
    logic [ID_W-1:0]     q_next;

    assign o_ready   = !r_out_valid || i_ready;
    assign in_accept = i_valid && o_ready;
    assign id_ok     = ({1'b0, i_cache_id} < NumCachesW);
    assign q_next    = next_id(r_queried);

    always_comb begin
        n_phase     = r_phase;
        n_initiator = r_initiator;
        n_queried   = r_queried;
        n_supplier  = r_supplier;
        n_hit_seen  = r_hit_seen;
        n_held_addr = r_held_addr;
        n_is_store  = r_is_store;
        emit        = 1'b0;
        n_action    = ACT_QUERY;
        n_target    = '0;
        if (in_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if ((i_command == CMD_LOAD || i_command == CMD_STORE) && id_ok) begin
                        n_initiator = i_cache_id;
                        n_held_addr = i_address[HELD_W-1:0];
                        emit        = 1'b1;
                        if (i_command == CMD_STORE) begin
                            n_is_store = 1'b1;
                            n_phase    = PH_WAIT_MEM;
                            n_action   = ACT_MEMORY;
                        end else begin
                            n_is_store = 1'b0;
                            n_hit_seen = 1'b0;
                            n_queried  = next_id(i_cache_id);
                            n_phase    = PH_QUERY;
                            n_action   = ACT_QUERY;
                            n_target   = next_id(i_cache_id);
                        end
                    end
                end
                PH_QUERY: begin
                    if (i_command == CMD_ANSWER && i_cache_id == r_queried) begin
                        emit = 1'b1;
                        if (i_hit && r_hit_seen) begin
                            n_hit_seen = 1'b0;
                            n_phase    = PH_WAIT_MEM;
                            n_action   = ACT_MEMORY;
                        end else begin
                            if (i_hit) begin
                                n_hit_seen = 1'b1;
                                n_supplier = r_queried;
                            end
                            n_queried = q_next;
                            if (q_next == r_initiator) begin
                                if (i_hit || r_hit_seen) begin
                                    n_hit_seen = 1'b0;
                                    n_phase    = PH_WAIT_CACHE;
                                    n_action   = ACT_READ_CACHE;
                                    n_target   = i_hit ? r_queried : r_supplier;
                                end else begin
                                    n_phase  = PH_WAIT_MEM;
                                    n_action = ACT_MEMORY;
                                end
                            end else begin
                                n_action = ACT_QUERY;
                                n_target = q_next;
                            end
                        end
                    end
                end
                PH_WAIT_CACHE: begin
                    if (i_command == CMD_CACHE_ACK) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_WAIT_MEM: begin
                    if (i_command == CMD_MEM_ACK) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_initiator <= '0;
            r_queried   <= '0;
            r_supplier  <= '0;
            r_hit_seen  <= 1'b0;
            r_held_addr <= '0;
            r_is_store  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_initiator <= n_initiator;
            r_queried   <= n_queried;
            r_supplier  <= n_supplier;
            r_hit_seen  <= n_hit_seen;
            r_held_addr <= n_held_addr;
            r_is_store  <= n_is_store;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_action    <= n_action;
            r_target    <= n_target;
            r_out_addr  <= n_held_addr;
            r_out_init  <= n_initiator;
            r_out_store <= n_is_store;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_action          = r_action;
    assign o_target_cache    = r_target;
    assign o_request_address = ADDR_FIELD_W'(r_out_addr);
    assign o_initiator       = r_out_init;
    assign o_is_store        = r_out_store;

    a_query_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_QUERY) |-> (r_queried != r_initiator))
        else $error("queried cache equals initiator during a query round");

    a_ids_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_queried} < NumCachesW) && ({1'b0, r_initiator} < NumCachesW))
        else $error("cache id register beyond cache count");

    a_wait_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (r_phase == PH_WAIT_MEM || r_phase == PH_WAIT_CACHE))
        |=> (r_out_valid == $past(r_out_valid && !i_ready)))
        else $error("result produced in a wait phase");

    a_read_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_action == ACT_READ_CACHE) |=> (r_phase == PH_WAIT_CACHE && r_out_valid))
        else $error("cache read issued without entering cache wait");

    a_memory_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_action == ACT_MEMORY) |=> (r_phase == PH_WAIT_MEM && o_target_cache == '0))
        else $error("memory forward issued without entering memory wait");

endmodule
